[hw/rtl/dsa_pkg.sv]
// dsa_pkg: shared types and constants of the descriptor slot allocator
// beat structs, operation and status codes, register indexes, controller command/status
// no dependencies
`default_nettype none

package dsa_pkg;

    // field widths fixed by the beat format
    localparam int SLOT_W   = 10;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int ADDR_W   = 64;
    localparam int LIMIT_W  = 11;
    localparam int STRIDE_W = 13;
    localparam int FRESH_W  = LIMIT_W;
    localparam int PROD_W   = FRESH_W + STRIDE_W;
    localparam int CFG_IDX_W = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_ALLOC     = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE      = 2'd1;
    localparam logic [OP_W-1:0] OP_TRANSLATE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_STRIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CPU_BASE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GPU_BASE    = 2'd3;

    // configuration reset values
    localparam logic [LIMIT_W-1:0]  SLOT_LIMIT_RST  = 11'd1024;
    localparam logic [STRIDE_W-1:0] SLOT_STRIDE_RST = 13'd32;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot_in;
    } in_beat_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_out;
        logic [ADDR_W-1:0]   cpu_address;
        logic [ADDR_W-1:0]   gpu_address;
    } out_beat_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input beat
        logic exec;      // queue / bump counter decision
        logic take_ram;  // slot comes from queue read data
        logic mul;       // slot times stride
        logic add;       // bases plus offset into output register
    } dsa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic queue_read; // exec is reading the free queue
    } dsa_stat_t;

endpackage

`default_nettype wire

[hw/rtl/dsa_ram.sv]
// dsa_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module dsa_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hw/rtl/dsa_ctrl.sv]
// dsa_ctrl: sequencer of the descriptor slot allocator
// depends on dsa_pkg
`default_nettype none

module dsa_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_stall,
    output      logic               out_valid,
    input  wire logic               out_stall,
    input  wire dsa_pkg::dsa_stat_t stat,
    output      dsa_pkg::dsa_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_RDWAIT = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_ADD    = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_stall     = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = stat.queue_read ? ST_RDWAIT : ST_MUL;
            end
            ST_RDWAIT:
            begin
                cmd.take_ram = 1'b1;
                state_next   = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.add    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg && out_stall) || cmd.add;
    assign out_valid      = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_add_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add |-> (!out_valid_reg || !out_stall))
        else $error("output register overwritten while a beat is held");
    a_valid_from_add: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.add))
        else $error("output valid rose without a result");
    a_take_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_ram |-> $past(cmd.exec && stat.queue_read))
        else $error("queue data taken without a read");
`endif

endmodule

`default_nettype wire

[hw/rtl/dsa_dp.sv]
// dsa_dp: datapath of the descriptor slot allocator
// free queue pointers and ram, bump counter, config registers, address arithmetic
// depends on dsa_pkg and dsa_ram
`default_nettype none

module dsa_dp #(
    parameter int MAX_SLOTS = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire dsa_pkg::in_beat_t                 in_beat,
    output      dsa_pkg::out_beat_t                out_beat,
    input  wire logic                              cfg_we,
    input  wire logic [dsa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dsa_pkg::ADDR_W-1:0]        cfg_data,
    input  wire dsa_pkg::dsa_cmd_t                 cmd,
    output      dsa_pkg::dsa_stat_t                stat
);

    localparam int PTR_W = $clog2(MAX_SLOTS);
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_SLOTS - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_SLOTS);

    // configuration
    logic [dsa_pkg::LIMIT_W-1:0]  slot_limit_reg;
    logic [dsa_pkg::STRIDE_W-1:0] slot_stride_reg;
    logic [dsa_pkg::ADDR_W-1:0]   cpu_base_reg;
    logic [dsa_pkg::ADDR_W-1:0]   gpu_base_reg;

    // queue and bump state
    logic [PTR_W-1:0]            head_reg;
    logic [PTR_W-1:0]            tail_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [dsa_pkg::FRESH_W-1:0] fresh_reg;

    // item under work
    logic [dsa_pkg::OP_W-1:0]     op_reg;
    logic [dsa_pkg::SLOT_W-1:0]   slot_in_reg;
    logic [dsa_pkg::FRESH_W-1:0]  slot_reg;
    logic [dsa_pkg::STATUS_W-1:0] status_reg;
    logic                         with_addr_reg;
    logic [dsa_pkg::PROD_W-1:0]   prod_reg;
    dsa_pkg::out_beat_t           out_reg;

    logic                        queue_empty;
    logic                        queue_full;
    logic                        fresh_ok;
    logic                        ram_re;
    logic                        ram_we;
    logic [dsa_pkg::SLOT_W-1:0]  ram_rdata;
    logic [dsa_pkg::ADDR_W-1:0]  offset;

    assign queue_empty = (count_reg == '0);
    assign queue_full  = (count_reg == CNT_FULL);
    assign fresh_ok    = (fresh_reg < slot_limit_reg)
                         && (32'(fresh_reg) < 32'(MAX_SLOTS));
    assign ram_re      = cmd.exec && (op_reg == dsa_pkg::OP_ALLOC) && !queue_empty;
    assign ram_we      = cmd.exec && (op_reg == dsa_pkg::OP_FREE) && !queue_full;
    assign stat.queue_read = ram_re;

    dsa_ram #(
        .WIDTH (dsa_pkg::SLOT_W),
        .DEPTH (MAX_SLOTS)
    ) u_queue (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (slot_in_reg),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // config writes and queue / bump control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_limit_reg  <= dsa_pkg::SLOT_LIMIT_RST;
            slot_stride_reg <= dsa_pkg::SLOT_STRIDE_RST;
            cpu_base_reg    <= '0;
            gpu_base_reg    <= '0;
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            fresh_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    dsa_pkg::REG_SLOT_LIMIT:
                        slot_limit_reg <= cfg_data[dsa_pkg::LIMIT_W-1:0];
                    dsa_pkg::REG_SLOT_STRIDE:
                        slot_stride_reg <= cfg_data[dsa_pkg::STRIDE_W-1:0];
                    dsa_pkg::REG_CPU_BASE:
                        cpu_base_reg <= cfg_data;
                    dsa_pkg::REG_GPU_BASE:
                        gpu_base_reg <= cfg_data;
                    default:
                        cpu_base_reg <= cpu_base_reg;
                endcase
            end
            if (ram_re)
            begin
                head_reg  <= (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
                count_reg <= count_reg - 1'b1;
            end
            else if (ram_we)
            begin
                tail_reg  <= (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.exec && (op_reg == dsa_pkg::OP_ALLOC) && queue_empty && fresh_ok)
            begin
                fresh_reg <= fresh_reg + 1'b1;
            end
        end
    end

    assign offset = {{(dsa_pkg::ADDR_W - dsa_pkg::PROD_W){1'b0}}, prod_reg};

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= in_beat.op;
            slot_in_reg <= in_beat.slot_in;
        end
        if (cmd.exec)
        begin
            status_reg    <= dsa_pkg::STATUS_OK;
            with_addr_reg <= 1'b1;
            slot_reg      <= {1'b0, slot_in_reg};
            case (op_reg)
                dsa_pkg::OP_ALLOC:
                begin
                    if (queue_empty)
                    begin
                        if (fresh_ok)
                        begin
                            slot_reg <= fresh_reg;
                        end
                        else
                        begin
                            status_reg    <= dsa_pkg::STATUS_EMPTY;
                            with_addr_reg <= 1'b0;
                            slot_reg      <= '0;
                        end
                    end
                end
                dsa_pkg::OP_FREE:
                begin
                    if (queue_full)
                    begin
                        status_reg <= dsa_pkg::STATUS_DROPPED;
                    end
                end
                default:
                begin
                    // translate, and the unused code behaves the same
                    status_reg <= dsa_pkg::STATUS_OK;
                end
            endcase
        end
        if (cmd.take_ram)
        begin
            slot_reg <= {1'b0, ram_rdata};
        end
        if (cmd.mul)
        begin
            prod_reg <= slot_reg * slot_stride_reg;
        end
        if (cmd.add)
        begin
            out_reg.status      <= status_reg;
            out_reg.slot_out    <= slot_reg[dsa_pkg::SLOT_W-1:0];
            out_reg.cpu_address <= with_addr_reg ? cpu_base_reg + offset : '0;
            out_reg.gpu_address <= with_addr_reg ? gpu_base_reg + offset : '0;
        end
    end

    assign out_beat = out_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("free queue count beyond depth");
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue pop did not lower the count");
    a_no_rw_same: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_re && ram_we))
        else $error("queue read and write in one item");
`endif

endmodule

`default_nettype wire

[hw/rtl/descriptor_slot_allocator.sv]
// descriptor_slot_allocator: top level, free-list slot allocator with address translation
// instantiates dsa_ctrl and dsa_dp; types from dsa_pkg
//
//   channel  direction  handshake            payload
//   in       into block in_valid / in_stall   in_beat  (op, slot_in)
//   out      from block out_valid / out_stall out_beat (status, slot_out, cpu/gpu address)
//   cfg      into block cfg_we                cfg_index, cfg_data
//
// the result beat is written to the output register by the add step; an allocate served
// from the free queue adds a read wait step for the queue ram's registered read
// the next input beat is taken only once the sequencer is back in idle after the add
// the sequencer steps exec, optional queue read, multiply, add; one item at a time
// reset is asynchronous active low; the free queue ram holds no reset and needs no clearing
// a held result does not block the next beat: it is taken while the result waits and
// only the final add step waits for the output register to drain
`default_nettype none

module descriptor_slot_allocator #(
    parameter int MAX_SLOTS = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input beats
    input  wire logic                          in_valid,
    output      logic                          in_stall,
    input  wire dsa_pkg::in_beat_t             in_beat,
    // result beats
    output      logic                          out_valid,
    input  wire logic                          out_stall,
    output      dsa_pkg::out_beat_t            out_beat,
    // register writes
    input  wire logic                          cfg_we,
    input  wire logic [dsa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [dsa_pkg::ADDR_W-1:0]    cfg_data
);

    // command and status between sequencer and datapath
    dsa_pkg::dsa_cmd_t  cmd;
    dsa_pkg::dsa_stat_t stat;

    // sequencer: accept, step the item, hand the result to the output register
    dsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: queue, bump counter, config, address arithmetic
    dsa_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_beat   (in_beat),
        .out_beat  (out_beat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire

[dv/tb_descriptor_slot_allocator.sv]
// tb_descriptor_slot_allocator: self-checking testbench for the descriptor slot allocator
// predicts every result beat from a shadow free queue and bump counter, compares per field
// depends on dsa_pkg and descriptor_slot_allocator

module tb_descriptor_slot_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_SLOTS   = 1024;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_LIMIT = 10;
    localparam int SETTLE_CYCLES = 10;
    // spare op code, the block treats it as a translate
    localparam logic [dsa_pkg::OP_W-1:0] OP_SPARE = 2'd3;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    dsa_pkg::in_beat_t             in_beat;
    logic                          out_valid;
    logic                          out_stall;
    dsa_pkg::out_beat_t            out_beat;
    logic                          cfg_we;
    logic [dsa_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [dsa_pkg::ADDR_W-1:0]    cfg_data;

    descriptor_slot_allocator #(
        .MAX_SLOTS (POOL_SLOTS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_beat   (in_beat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_beat  (out_beat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow registers as the block should hold them
    logic [dsa_pkg::LIMIT_W-1:0]  limit_q;
    logic [dsa_pkg::STRIDE_W-1:0] stride_q;
    logic [dsa_pkg::ADDR_W-1:0]   cpu_base_q;
    logic [dsa_pkg::ADDR_W-1:0]   gpu_base_q;

    // shadow free queue and bump counter
    logic [dsa_pkg::SLOT_W-1:0]   recycle_ring [POOL_SLOTS];
    int                           ring_rd;
    int                           ring_wr;
    int                           ring_fill;
    logic [dsa_pkg::FRESH_W-1:0]  fresh_next;

    dsa_pkg::in_beat_t            pending_reqs[$];   // request beats not yet offered
    dsa_pkg::out_beat_t           answers_due[$];    // predicted result beats, oldest first

    int                  send_idle_pct;
    int                  recv_stall_pct;
    logic                in_took;           // request beat accepted at the last rising edge
    int                  mismatches;
    int                  results_seen;
    int                  refusals;
    int                  drops;
    int                  requests_sent;
    int                  cycle_count;

    // one request against the shadow state: pop or bump on allocate, push on free
    function automatic dsa_pkg::out_beat_t serve_request(dsa_pkg::in_beat_t req);
        dsa_pkg::out_beat_t         ans;
        logic [dsa_pkg::FRESH_W:0]  cap;
        logic [dsa_pkg::ADDR_W-1:0] offset;
        ans          = '0;
        ans.status   = dsa_pkg::STATUS_OK;
        ans.slot_out = req.slot_in;
        case (req.op)
            dsa_pkg::OP_ALLOC:
            begin
                // limits above the pool stop at the pool size
                cap = (int'(limit_q) > POOL_SLOTS) ? (dsa_pkg::FRESH_W + 1)'(POOL_SLOTS)
                                                   : {1'b0, limit_q};
                if (ring_fill != 0)
                begin
                    ans.slot_out = recycle_ring[ring_rd];
                    ring_rd      = (ring_rd == POOL_SLOTS - 1) ? 0 : ring_rd + 1;
                    ring_fill--;
                end
                else if ({1'b0, fresh_next} < cap)
                begin
                    ans.slot_out = fresh_next[dsa_pkg::SLOT_W-1:0];
                    fresh_next++;
                end
                else
                begin
                    // out of slots: zero slot and zero addresses
                    ans.status   = dsa_pkg::STATUS_EMPTY;
                    ans.slot_out = '0;
                    return ans;
                end
            end
            dsa_pkg::OP_FREE:
            begin
                if (ring_fill >= POOL_SLOTS)
                    ans.status = dsa_pkg::STATUS_DROPPED;
                else
                begin
                    // double frees go in unchecked
                    recycle_ring[ring_wr] = req.slot_in;
                    ring_wr = (ring_wr == POOL_SLOTS - 1) ? 0 : ring_wr + 1;
                    ring_fill++;
                end
            end
            default: ;  // translate and the spare code leave the state alone
        endcase
        offset = dsa_pkg::ADDR_W'(ans.slot_out) * dsa_pkg::ADDR_W'(stride_q);
        ans.cpu_address = cpu_base_q + offset;
        ans.gpu_address = gpu_base_q + offset;
        return ans;
    endfunction

    function automatic void note_mismatch(string field, logic [dsa_pkg::ADDR_W-1:0] want,
                                          logic [dsa_pkg::ADDR_W-1:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch in %s at %0t: expected %h, got %h", field, $time, want, got);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // monitor: register writes, accepted requests and accepted results, all at the rising edge
    always @(posedge clk)
    begin : monitor
        dsa_pkg::out_beat_t want;
        in_took <= in_valid && !in_stall;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_descriptor_slot_allocator: FAIL");
            $finish;
        end
        else if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    dsa_pkg::REG_SLOT_LIMIT:  limit_q    = cfg_data[dsa_pkg::LIMIT_W-1:0];
                    dsa_pkg::REG_SLOT_STRIDE: stride_q   = cfg_data[dsa_pkg::STRIDE_W-1:0];
                    dsa_pkg::REG_CPU_BASE:    cpu_base_q = cfg_data;
                    dsa_pkg::REG_GPU_BASE:    gpu_base_q = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                answers_due.push_back(serve_request(in_beat));
                requests_sent++;
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (answers_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("result beat at %0t with nothing expected: status %0d slot %0d",
                                 $time, out_beat.status, out_beat.slot_out);
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (want.status == dsa_pkg::STATUS_EMPTY)
                        refusals++;
                    if (want.status == dsa_pkg::STATUS_DROPPED)
                        drops++;
                    if (out_beat.status !== want.status)
                        note_mismatch("status", want.status, out_beat.status);
                    if (out_beat.slot_out !== want.slot_out)
                        note_mismatch("slot_out", want.slot_out, out_beat.slot_out);
                    if (out_beat.cpu_address !== want.cpu_address)
                        note_mismatch("cpu_address", want.cpu_address, out_beat.cpu_address);
                    if (out_beat.gpu_address !== want.gpu_address)
                        note_mismatch("gpu_address", want.gpu_address, out_beat.gpu_address);
                end
            end
        end
    end

    // driver: offers the next request beat and throttles the result side at the falling edge
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        // a beat still waiting keeps its payload and its valid
        if (!in_valid || in_took)
        begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_beat  <= pending_reqs.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    task automatic push_item(logic [dsa_pkg::OP_W-1:0] op, int slot);
        dsa_pkg::in_beat_t b;
        b.op      = op;
        b.slot_in = dsa_pkg::SLOT_W'(slot);
        pending_reqs.push_back(b);
    endtask

    // random mix of all four op codes
    task automatic queue_mixed(int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            push_item(r < 35 ? dsa_pkg::OP_ALLOC : r < 70 ? dsa_pkg::OP_FREE :
                      r < 90 ? dsa_pkg::OP_TRANSLATE : OP_SPARE,
                      $urandom_range(0, POOL_SLOTS - 1));
        end
    endtask

    // long run of one op with random slots, a translate now and then as noise
    task automatic queue_burst(logic [dsa_pkg::OP_W-1:0] op, int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                push_item(dsa_pkg::OP_TRANSLATE, $urandom_range(0, POOL_SLOTS - 1));
            push_item(op, $urandom_range(0, POOL_SLOTS - 1));
        end
    endtask

    // everything offered, accepted and answered
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || (in_valid && !in_took) || answers_due.size() != 0);
    endtask

    task automatic write_reg(logic [dsa_pkg::CFG_IDX_W-1:0] idx,
                             logic [dsa_pkg::ADDR_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // new register setting, only once the block has gone quiet
    task automatic retune(logic [dsa_pkg::LIMIT_W-1:0] lim,
                          logic [dsa_pkg::STRIDE_W-1:0] stride,
                          logic [dsa_pkg::ADDR_W-1:0] cpu, logic [dsa_pkg::ADDR_W-1:0] gpu);
        wait_drained();
        write_reg(dsa_pkg::REG_SLOT_LIMIT, dsa_pkg::ADDR_W'(lim));
        write_reg(dsa_pkg::REG_SLOT_STRIDE, dsa_pkg::ADDR_W'(stride));
        write_reg(dsa_pkg::REG_CPU_BASE, cpu);
        write_reg(dsa_pkg::REG_GPU_BASE, gpu);
        @(posedge clk);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_beat        = '0;
        out_stall      = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = dsa_pkg::REG_SLOT_LIMIT;
        cfg_data       = '0;
        in_took        = 1'b0;
        limit_q        = dsa_pkg::SLOT_LIMIT_RST;
        stride_q       = dsa_pkg::SLOT_STRIDE_RST;
        cpu_base_q     = '0;
        gpu_base_q     = '0;
        ring_rd        = 0;
        ring_wr        = 0;
        ring_fill      = 0;
        fresh_next     = '0;
        mismatches     = 0;
        results_seen   = 0;
        refusals       = 0;
        drops          = 0;
        requests_sent  = 0;
        cycle_count    = 0;
        send_idle_pct  = 6;
        recv_stall_pct = 58;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // reset setting: fresh slots, free of a never-issued slot, recycle oldest first
        push_item(dsa_pkg::OP_ALLOC, POOL_SLOTS - 1);
        push_item(dsa_pkg::OP_ALLOC, 0);
        push_item(dsa_pkg::OP_FREE, POOL_SLOTS - 1);
        push_item(dsa_pkg::OP_FREE, 0);
        push_item(dsa_pkg::OP_TRANSLATE, POOL_SLOTS - 1);
        push_item(OP_SPARE, 'h2AA);
        push_item(dsa_pkg::OP_TRANSLATE, 'h155);
        push_item(dsa_pkg::OP_ALLOC, 'h155);
        push_item(dsa_pkg::OP_ALLOC, 'h2AA);
        push_item(dsa_pkg::OP_ALLOC, 0);

        // zero limit, widest stride, bases that wrap: refusals and double free
        retune('0, '1, '1, 64'h8000_0000_0000_0001);
        push_item(dsa_pkg::OP_ALLOC, 0);
        push_item(dsa_pkg::OP_FREE, 5);
        push_item(dsa_pkg::OP_FREE, 5);
        push_item(dsa_pkg::OP_ALLOC, 0);
        push_item(dsa_pkg::OP_ALLOC, 0);
        push_item(dsa_pkg::OP_ALLOC, POOL_SLOTS - 1);
        push_item(dsa_pkg::OP_TRANSLATE, POOL_SLOTS - 1);
        push_item(OP_SPARE, POOL_SLOTS - 1);

        // limit beyond the pool
        retune('1, 13'd4096, {$urandom, $urandom}, '0);
        push_item(dsa_pkg::OP_ALLOC, 0);
        push_item(dsa_pkg::OP_TRANSLATE, 512);
        push_item(dsa_pkg::OP_FREE, 1);
        push_item(OP_SPARE, 0);

        // random mix, limit just past the bump counter so it runs dry
        retune(dsa_pkg::LIMIT_W'(fresh_next + $urandom_range(0, 12)),
               dsa_pkg::STRIDE_W'($urandom_range(0, 4096)),
               {$urandom, $urandom}, {$urandom, $urandom});
        queue_mixed(25);

        // sender idles more than the receiver stalls; limit of one, only recycling works
        retune(11'd1, 13'd4096, '0, '1);
        send_idle_pct  = 58;
        recv_stall_pct = 6;
        queue_mixed(25);

        // no idling: fill the free queue past full so the last frees are dropped
        retune('1, dsa_pkg::STRIDE_W'($urandom_range(0, 8191)), {$urandom, $urandom},
               {$urandom, $urandom});
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_burst(dsa_pkg::OP_FREE, POOL_SLOTS - ring_fill + 4);
        queue_mixed(15);

        // let any stray result beat show up before the verdict
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("checked %0d results for %0d requests over six register settings",
                 results_seen, requests_sent);
        $display("%0d allocations refused, %0d frees dropped on a full queue, %0d mismatches",
                 refusals, drops, mismatches);
        if (mismatches == 0 && answers_due.size() == 0)
            $display("tb_descriptor_slot_allocator: PASS");
        else
            $display("tb_descriptor_slot_allocator: FAIL");
        $finish;
    end

endmodule
